### hw/rtl/raised_cosine_disk_field_defines.svh
// ---------------------------------------------------------------------------
// raised_cosine_disk_field_defines
// assertion macros for the raised-cosine disk field block
// ---------------------------------------------------------------------------
`ifndef RAISED_COSINE_DISK_FIELD_DEFINES_SVH
`define RAISED_COSINE_DISK_FIELD_DEFINES_SVH

`ifndef SYNTHESIS
`define RCDF_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rcdf implication check failed");
`define RCDF_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rcdf forbidden condition seen");
`else
`define RCDF_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define RCDF_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

### hw/rtl/rcdf_pkg.sv
// ---------------------------------------------------------------------------
// rcdf_pkg
// types, constants and the weight table function of the disk field block
// ---------------------------------------------------------------------------
package rcdf_pkg;

   localparam int COS_TABLE_ENTRIES_DEF = 256;
   localparam int FRAC_BITS_DEF         = 16;

   localparam int W_BITS       = 16;
   localparam int WEIGHT_W     = W_BITS + 1;
   localparam int SQRT_STEPS   = 32;
   localparam int DIST_STAGES  = 3;
   localparam int CLASS_STAGES = 1;
   localparam int BLEND_STAGES = 4;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   typedef enum logic [2:0] {
      CSR_CENTER_X      = 3'd0,
      CSR_CENTER_Y      = 3'd1,
      CSR_DISK_RADIUS   = 3'd2,
      CSR_BAND_WIDTH    = 3'd3,
      CSR_INSIDE_VALUE  = 3'd4,
      CSR_OUTSIDE_VALUE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_INSIDE  = 2'd0,
      CLS_BAND    = 2'd1,
      CLS_OUTSIDE = 2'd2
   } band_class_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [31:0]        node_tag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] field_value;
      logic [31:0]        result_tag;
   } rsp_type;

   typedef struct packed {
      band_class_type cls;
      logic [31:0]    tag;
   } side_type;

   function automatic logic [63:0] clamp_pos(input logic signed [63:0] v);
      return (v < 0) ? 64'd0 : 64'(v);
   endfunction

   // cos^2(a) in Q16 from angle a in Q30, horner series through a^12
   function automatic logic [WEIGHT_W-1:0] weight_of_angle(input logic [63:0] a);
      logic [63:0]        x;
      logic signed [63:0] c;
      logic [63:0]        c2;
      x  = (a * a) >> 30;
      c  = signed'(ONE_Q30);
      c  = signed'(ONE_Q30) - signed'(((x * clamp_pos(c)) >> 30) / 64'd132);
      c  = signed'(ONE_Q30) - signed'(((x * clamp_pos(c)) >> 30) / 64'd90);
      c  = signed'(ONE_Q30) - signed'(((x * clamp_pos(c)) >> 30) / 64'd56);
      c  = signed'(ONE_Q30) - signed'(((x * clamp_pos(c)) >> 30) / 64'd30);
      c  = signed'(ONE_Q30) - signed'(((x * clamp_pos(c)) >> 30) / 64'd12);
      c  = signed'(ONE_Q30) - signed'(((x * clamp_pos(c)) >> 30) / 64'd2);
      if (c < 0) begin
         c = 64'sd0;
      end
      if (c > signed'(ONE_Q30)) begin
         c = signed'(ONE_Q30);
      end
      c2 = 64'(c) * 64'(c);
      return WEIGHT_W'((c2 + (64'd1 << (59 - W_BITS))) >> (60 - W_BITS));
   endfunction

endpackage

### hw/rtl/rcdf_dist.sv
// ---------------------------------------------------------------------------
// rcdf_dist
// offset from centre, squares and saturated sum of squares, three stages
// ---------------------------------------------------------------------------
module rcdf_dist (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rcdf_pkg::req_type   in_req,
   input  logic signed [31:0]  center_x,
   input  logic signed [31:0]  center_y,
   output logic                out_valid,
   output logic [63:0]         out_sum,
   output logic [31:0]         out_tag
);
   import rcdf_pkg::*;

   logic [DIST_STAGES-1:0] vld_ff;
   logic [31:0]            ax_ff, ay_ff, ax_in, ay_in;
   logic [63:0]            sqx_ff, sqy_ff;
   logic [63:0]            sum_ff, sum_in;
   logic [31:0]            tag0_ff, tag1_ff, tag2_ff;
   logic signed [32:0]     dx, dy;
   logic [64:0]            sum_wide;

   always_comb begin
      dx    = {in_req.point_x[31], in_req.point_x} - {center_x[31], center_x};
      dy    = {in_req.point_y[31], in_req.point_y} - {center_y[31], center_y};
      ax_in = dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
      ay_in = dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
      sum_wide = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      sum_in   = sum_wide[64] ? '1 : sum_wide[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIST_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      tag0_ff <= in_req.node_tag;
      sqx_ff  <= 64'(ax_ff) * 64'(ax_ff);
      sqy_ff  <= 64'(ay_ff) * 64'(ay_ff);
      tag1_ff <= tag0_ff;
      sum_ff  <= sum_in;
      tag2_ff <= tag1_ff;
   end

   assign out_valid = vld_ff[DIST_STAGES-1];
   assign out_sum   = sum_ff;
   assign out_tag   = tag2_ff;

endmodule

### hw/rtl/rcdf_isqrt.sv
// ---------------------------------------------------------------------------
// rcdf_isqrt
// floor square root of a 64-bit value, one result bit per stage
// ---------------------------------------------------------------------------
module rcdf_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_radicand,
   input  logic [31:0] in_tag,
   output logic        out_valid,
   output logic [31:0] out_root,
   output logic [31:0] out_tag
);
   import rcdf_pkg::*;

   localparam int RemW = 36;

   logic              vld_ff  [SQRT_STEPS];
   logic [63:0]       rad_ff  [SQRT_STEPS];
   logic [RemW-1:0]   rem_ff  [SQRT_STEPS];
   logic [31:0]       root_ff [SQRT_STEPS];
   logic [31:0]       tag_ff  [SQRT_STEPS];

   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
      logic            vld_cur;
      logic [63:0]     rad_cur, rad_in;
      logic [RemW-1:0] rem_cur, rem_in, rem_sh, trial;
      logic [31:0]     root_cur, root_in, tag_cur;
      logic            fits;

      if (s == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rad_cur  = in_radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign tag_cur  = in_tag;
      end else begin : g_next
         assign vld_cur  = vld_ff[s-1];
         assign rad_cur  = rad_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign tag_cur  = tag_ff[s-1];
      end

      always_comb begin
         rem_sh  = {rem_cur[RemW-3:0], rad_cur[63:62]};
         trial   = {2'b00, root_cur, 2'b01};
         fits    = (rem_sh >= trial);
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_cur[30:0], fits};
         rad_in  = {rad_cur[61:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[s]  <= rad_in;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         tag_ff[s]  <= tag_cur;
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_tag   = tag_ff[SQRT_STEPS-1];

endmodule

### hw/rtl/rcdf_div.sv
// ---------------------------------------------------------------------------
// rcdf_div
// band position quotient, restoring division with one quotient bit per stage
// ---------------------------------------------------------------------------
module rcdf_div #(
   parameter int FRAC_BITS = rcdf_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [32:0]           in_num,
   input  logic [31:0]           in_den,
   input  rcdf_pkg::side_type    in_side,
   output logic                  out_valid,
   output logic [FRAC_BITS-1:0]  out_quot,
   output rcdf_pkg::side_type    out_side
);
   import rcdf_pkg::*;

   logic                 vld_ff  [FRAC_BITS];
   logic [32:0]          rem_ff  [FRAC_BITS];
   logic [31:0]          den_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] quot_ff [FRAC_BITS];
   side_type             side_ff [FRAC_BITS];

   for (genvar s = 0; s < FRAC_BITS; s++) begin : g_step
      logic                 vld_cur, fits;
      logic [32:0]          rem_cur, rem_in;
      logic [33:0]          rem_sh;
      logic [31:0]          den_cur;
      logic [FRAC_BITS-1:0] quot_cur, quot_in;
      side_type             side_cur;

      if (s == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rem_cur  = in_num;
         assign den_cur  = in_den;
         assign quot_cur = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign vld_cur  = vld_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign den_cur  = den_ff[s-1];
         assign quot_cur = quot_ff[s-1];
         assign side_cur = side_ff[s-1];
      end

      always_comb begin
         rem_sh  = {rem_cur, 1'b0};
         fits    = (rem_sh >= {2'b00, den_cur});
         rem_in  = fits ? 33'(rem_sh - {2'b00, den_cur}) : rem_sh[32:0];
         quot_in = {quot_cur[FRAC_BITS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_cur;
         quot_ff[s] <= quot_in;
         side_ff[s] <= side_cur;
      end
   end

   assign out_valid = vld_ff[FRAC_BITS-1];
   assign out_quot  = quot_ff[FRAC_BITS-1];
   assign out_side  = side_ff[FRAC_BITS-1];

endmodule

### hw/rtl/rcdf_blend.sv
// ---------------------------------------------------------------------------
// rcdf_blend
// table index, raised-cosine weight lookup, blend multiply and saturation
// ---------------------------------------------------------------------------
module rcdf_blend #(
   parameter int COS_TABLE_ENTRIES = rcdf_pkg::COS_TABLE_ENTRIES_DEF,
   parameter int FRAC_BITS         = rcdf_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [FRAC_BITS-1:0]  in_pos,
   input  rcdf_pkg::side_type    in_side,
   input  logic signed [31:0]    inside_value,
   input  logic signed [31:0]    outside_value,
   output logic                  out_valid,
   output rcdf_pkg::rsp_type     out_rsp
);
   import rcdf_pkg::*;

   localparam int KW     = $clog2(COS_TABLE_ENTRIES + 1);
   localparam int PW     = FRAC_BITS + KW + 1;
   localparam int TabLen = 2 ** KW;

   logic [WEIGHT_W-1:0] wtab [TabLen];

   // raised-cosine weights, entries past the last one repeat it
   for (genvar k = 0; k < TabLen; k++) begin : g_tab
      localparam int          Kc  = (k > COS_TABLE_ENTRIES) ? COS_TABLE_ENTRIES : k;
      localparam logic [63:0] Ang = (PI_Q30 * 64'(Kc)) / (64'd2 * 64'(COS_TABLE_ENTRIES));
      localparam logic [WEIGHT_W-1:0] WVal = weight_of_angle(Ang);
      assign wtab[k] = WVal;
   end

   logic [BLEND_STAGES-1:0] vld_ff;
   logic [KW-1:0]           k_ff, k_in;
   logic [PW-1:0]           kprod;
   logic [WEIGHT_W-1:0]     w_ff;
   logic signed [32:0]      diff_ff;
   logic signed [49:0]      prod_ff;
   side_type                side1_ff, side2_ff, side3_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic signed [49:0]      rounded;
   logic signed [33:0]      scaled;
   logic signed [34:0]      mixed;
   logic signed [31:0]      mixed_sat;

   always_comb begin
      kprod = PW'(in_pos) * PW'(COS_TABLE_ENTRIES) + (PW'(1) << (FRAC_BITS - 1));
      k_in  = kprod[FRAC_BITS +: KW];
   end

   always_comb begin
      rounded = prod_ff + 50'sd32768;
      scaled  = 34'(rounded >>> W_BITS);
      mixed   = 35'(outside_value) + 35'(scaled);
      if (mixed[34:31] != {4{mixed[34]}}) begin
         mixed_sat = mixed[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         mixed_sat = mixed[31:0];
      end
      rsp_in.result_tag = side3_ff.tag;
      case (side3_ff.cls)
         CLS_INSIDE: rsp_in.field_value = inside_value;
         CLS_BAND:   rsp_in.field_value = mixed_sat;
         default:    rsp_in.field_value = outside_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[BLEND_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      side1_ff <= in_side;
      w_ff     <= wtab[k_ff];
      diff_ff  <= 33'(inside_value) - 33'(outside_value);
      side2_ff <= side1_ff;
      prod_ff  <= 50'(diff_ff) * signed'({33'd0, w_ff});
      side3_ff <= side2_ff;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = vld_ff[BLEND_STAGES-1];
   assign out_rsp   = rsp_ff;

endmodule

### hw/rtl/raised_cosine_disk_field.sv
// ---------------------------------------------------------------------------
// raised_cosine_disk_field
// smooth disk mask: distance to a centre, raised-cosine blend across a band
// pipeline of 3 distance stages, 32 square root stages, 1 band stage,
// FRAC_BITS divide stages and 4 blend stages
// throughput is one transaction per cycle, busy is high only during reset
// synchronous reset clears all valid bits and loads the register defaults
// ---------------------------------------------------------------------------
`include "raised_cosine_disk_field_defines.svh"

module raised_cosine_disk_field #(
   parameter int COS_TABLE_ENTRIES = rcdf_pkg::COS_TABLE_ENTRIES_DEF,
   parameter int FRAC_BITS         = rcdf_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rcdf_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rcdf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import rcdf_pkg::*;

   localparam int Latency = DIST_STAGES + SQRT_STEPS + CLASS_STAGES + FRAC_BITS
                            + BLEND_STAGES;

   logic signed [31:0] center_x_ff, center_y_ff, inside_value_ff, outside_value_ff;
   logic [30:0]        disk_radius_ff, band_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= 32'sd0;
         center_y_ff      <= 32'sd0;
         disk_radius_ff   <= 31'd65536;
         band_width_ff    <= 31'd0;
         inside_value_ff  <= 32'sd65536;
         outside_value_ff <= 32'sd0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X:      center_x_ff      <= csr_wdata;
            CSR_CENTER_Y:      center_y_ff      <= csr_wdata;
            CSR_DISK_RADIUS:   disk_radius_ff   <= csr_wdata[30:0];
            CSR_BAND_WIDTH:    band_width_ff    <= csr_wdata[30:0];
            CSR_INSIDE_VALUE:  inside_value_ff  <= csr_wdata;
            CSR_OUTSIDE_VALUE: outside_value_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic req_fire;
   assign busy     = reset;
   assign req_fire = start && !busy;

   logic        dist_valid;
   logic [63:0] dist_sum;
   logic [31:0] dist_tag;

   rcdf_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .in_req    (req_data),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .out_valid (dist_valid),
      .out_sum   (dist_sum),
      .out_tag   (dist_tag)
   );

   logic        root_valid;
   logic [31:0] root_value, root_tag;

   rcdf_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dist_valid),
      .in_radicand (dist_sum),
      .in_tag      (dist_tag),
      .out_valid   (root_valid),
      .out_root    (root_value),
      .out_tag     (root_tag)
   );

   // band classification on doubled distance and doubled limits
   logic               cls_valid_ff;
   logic [32:0]        num_ff, num_in;
   logic [31:0]        den_ff;
   side_type           side_ff, side_in;
   logic signed [34:0] d2, lo2, hi2;

   always_comb begin
      d2  = signed'({2'b00, root_value, 1'b0});
      lo2 = signed'({3'b000, disk_radius_ff, 1'b0}) - signed'({4'b0000, band_width_ff});
      hi2 = signed'({3'b000, disk_radius_ff, 1'b0}) + signed'({4'b0000, band_width_ff});
      num_in      = 33'(d2 - lo2);
      side_in.tag = root_tag;
      if (d2 <= lo2) begin
         side_in.cls = CLS_INSIDE;
      end else if (d2 < hi2 && band_width_ff != 31'd0) begin
         side_in.cls = CLS_BAND;
      end else begin
         side_in.cls = CLS_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
      end else begin
         cls_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= {band_width_ff, 1'b0};
      side_ff <= side_in;
   end

   logic                 div_valid;
   logic [FRAC_BITS-1:0] div_quot;
   side_type             div_side;

   rcdf_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   rcdf_blend #(
      .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES),
      .FRAC_BITS         (FRAC_BITS)
   ) u_blend (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (div_valid),
      .in_pos        (div_quot),
      .in_side       (div_side),
      .inside_value  (inside_value_ff),
      .outside_value (outside_value_ff),
      .out_valid     (rsp_strobe),
      .out_rsp       (rsp_data)
   );

   `RCDF_ASSERT_IMPLIES(a_strobe_follows_accept, clock, reset, rsp_strobe, $past(req_fire, Latency))
   `RCDF_ASSERT_IMPLIES(a_tag_kept, clock, reset, rsp_strobe, rsp_data.result_tag == $past(req_data.node_tag, Latency))
   `RCDF_ASSERT_NEVER(a_flush_on_reset, clock, reset, $past(reset) && rsp_strobe)

endmodule
